// ----- hdl/chacha20_stream_xor_macros.svh -----
// Assertion macros for the ChaCha20 stream combiner.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/chacha_pkg.sv -----
// Shared constants and types for the ChaCha20 stream combiner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package chacha_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int DR_CNT_W      = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

   localparam int WORD_W      = 32;
   localparam int NUM_WORDS   = 16;
   localparam int BLOCK_BYTES = 64;
   localparam int POS_W       = 7;
   localparam int NUM_REGS    = 7;
   localparam int CSR_IDX_W   = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KEY0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CTR    = 3'd6;

   // The "expand 32-byte k" constant words.
   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

   // Quarter-round rotation distances, in the order they are applied.
   localparam int ROT_A = 16;
   localparam int ROT_B = 12;
   localparam int ROT_C = 8;
   localparam int ROT_D = 7;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

endpackage

// ----- hdl/chacha_qr.sv -----
// Shared ChaCha20 arithmetic unit: one half of a quarter round per cycle.
// Depends on chacha_pkg for the rotation distances.
`timescale 1ns / 1ps

module chacha_qr import chacha_pkg::*; (
   input  logic [WORD_W-1:0] a_word,
   input  logic [WORD_W-1:0] b_word,
   input  logic [WORD_W-1:0] c_word,
   input  logic [WORD_W-1:0] d_word,
   input  logic              second_half,
   output logic [WORD_W-1:0] a_new,
   output logic [WORD_W-1:0] b_new,
   output logic [WORD_W-1:0] c_new,
   output logic [WORD_W-1:0] d_new
);

   logic [WORD_W-1:0] d_mix;
   logic [WORD_W-1:0] b_mix;

   function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] w, int s);
      return (w << s) | (w >> (WORD_W - s));
   endfunction

   // The first adder also serves the final feed-forward addition.
   always_comb begin
      a_new = a_word + b_word;
      d_mix = d_word ^ a_new;
      d_new = second_half ? rotl(d_mix, ROT_C) : rotl(d_mix, ROT_A);
      c_new = c_word + d_new;
      b_mix = b_word ^ c_new;
      b_new = second_half ? rotl(b_mix, ROT_D) : rotl(b_mix, ROT_B);
   end

endmodule

// ----- hdl/chacha_core.sv -----
// ChaCha20 block sequencer: working state, round counters and feed-forward.
// Depends on chacha_pkg and the shared unit chacha_qr.
`timescale 1ns / 1ps

module chacha_core import chacha_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  block_type       init_words,
   output block_type       ks_words,
   output core_status_type status
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROUND = 3'b010,
      C_FINAL = 3'b100
   } core_state_type;

   core_state_type        cstate_ff, cstate_in;
   block_type             work_ff, work_in;
   block_type             round_work;
   logic                  half_ff, half_in;
   logic [2:0]            qr_cnt_ff, qr_cnt_in;
   logic [DR_CNT_W-1:0]   dr_cnt_ff, dr_cnt_in;
   logic [3:0]            fin_cnt_ff, fin_cnt_in;
   logic                  done_ff, done_in;
   logic [3:0][1:0]       row_amt;
   logic [WORD_W-1:0]     qa, qb, qc, qd;
   logic [WORD_W-1:0]     unit_b;

   // Rotate each row of the 4x4 state left by its own word count.
   function automatic block_type rotate_rows(block_type w, logic [3:0][1:0] amt);
      block_type  r;
      logic [1:0] src;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            src = 2'(col) + amt[row];
            r[row*4 + col] = w[row*4 + int'(src)];
         end
      end
      return r;
   endfunction

   // The unit always works on column 0; during feed-forward it adds word 0
   // and the matching input word.
   assign unit_b = (cstate_ff == C_FINAL) ? init_words[fin_cnt_ff] : work_ff[4];

   chacha_qr u_qr (
      .a_word      (work_ff[0]),
      .b_word      (unit_b),
      .c_word      (work_ff[8]),
      .d_word      (work_ff[12]),
      .second_half (half_ff),
      .a_new       (qa),
      .b_new       (qb),
      .c_new       (qc),
      .d_new       (qd)
   );

   // Rows shift one word per quarter round, so the next column or diagonal
   // lands in column 0. Ending the column pass also diagonalizes the rows,
   // and ending the diagonal pass undoes it.
   always_comb begin
      for (int row = 0; row < 4; row++) begin
         if (qr_cnt_ff == 3'd3) begin
            row_amt[row] = 2'(1 + row);
         end else if (qr_cnt_ff == 3'd7) begin
            row_amt[row] = 2'(5 - row);
         end else begin
            row_amt[row] = 2'd1;
         end
      end
   end

   always_comb begin
      round_work     = work_ff;
      round_work[0]  = qa;
      round_work[4]  = qb;
      round_work[8]  = qc;
      round_work[12] = qd;
   end

   always_comb begin
      cstate_in  = cstate_ff;
      work_in    = work_ff;
      half_in    = half_ff;
      qr_cnt_in  = qr_cnt_ff;
      dr_cnt_in  = dr_cnt_ff;
      fin_cnt_in = fin_cnt_ff;
      done_in    = 1'b0;
      unique case (cstate_ff)
         C_IDLE: begin
            if (start) begin
               work_in   = init_words;
               half_in   = 1'b0;
               qr_cnt_in = '0;
               dr_cnt_in = '0;
               cstate_in = C_ROUND;
            end
         end
         C_ROUND: begin
            if (!half_ff) begin
               work_in = round_work;
               half_in = 1'b1;
            end else begin
               work_in   = rotate_rows(round_work, row_amt);
               half_in   = 1'b0;
               qr_cnt_in = qr_cnt_ff + 3'd1;
               if (qr_cnt_ff == 3'd7) begin
                  dr_cnt_in = dr_cnt_ff + 1'b1;
                  if (dr_cnt_ff == DR_CNT_W'(DOUBLE_ROUNDS - 1)) begin
                     fin_cnt_in = '0;
                     cstate_in  = C_FINAL;
                  end
               end
            end
         end
         C_FINAL: begin
            // Word ring: after sixteen steps every word is back in place.
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
               work_in[i] = work_ff[i+1];
            end
            work_in[NUM_WORDS-1] = qa;
            fin_cnt_in = fin_cnt_ff + 4'd1;
            if (fin_cnt_ff == 4'd15) begin
               done_in   = 1'b1;
               cstate_in = C_IDLE;
            end
         end
         default: begin
            cstate_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cstate_ff  <= C_IDLE;
         half_ff    <= 1'b0;
         qr_cnt_ff  <= '0;
         dr_cnt_ff  <= '0;
         fin_cnt_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         cstate_ff  <= cstate_in;
         half_ff    <= half_in;
         qr_cnt_ff  <= qr_cnt_in;
         dr_cnt_ff  <= dr_cnt_in;
         fin_cnt_ff <= fin_cnt_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign ks_words    = work_ff;
   assign status.busy = (cstate_ff != C_IDLE);
   assign status.done = done_ff;

endmodule

// ----- hdl/chacha20_stream_xor.sv -----
// Top level of the ChaCha20 stream combiner: handshakes, configuration,
// block counter and byte selection. Depends on chacha_pkg, chacha_core and
// the assertion macros in chacha20_stream_xor_macros.svh.
//
//   Channel   Direction  Ports                                  Moves
//   req       in         req_valid/ready, data_byte, first_byte one byte request
//   rsp       out        rsp_valid/ready, out_byte              one combined byte
//   csr       in         csr_valid/ready, index, data           one register write
//
// A request that can use the current keystream block is accepted and its
// result is registered at the edge that accepts it. A request that needs
// a new block (first of a call, or block used up) starts the core, which
// runs ten double rounds on the shared half-quarter-round unit, each quarter
// round in two halves, then sixteen feed-forward steps; no further request
// is taken until that byte has been combined.
// Reset leaves the key, nonce and counter registers at zero and the block
// marked used up. A stalled result holds only its own register; the next
// request is taken as soon as that register drains in the same cycle.
`timescale 1ns / 1ps
`include "chacha20_stream_xor_macros.svh"

module chacha20_stream_xor import chacha_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_first_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,   // ready for a request
      ST_GEN  = 3'b010,   // waiting on a fresh keystream block
      ST_XOR  = 3'b100    // block ready; combine the held byte
   } xor_state_type;

   xor_state_type      state_ff, state_in;
   logic [3:0][63:0]   key_ff, key_in;
   logic [63:0]        nonce0_ff, nonce0_in;
   logic [31:0]        nonce1_ff, nonce1_in;
   logic [31:0]        init_ctr_ff, init_ctr_in;
   logic [31:0]        counter_ff, counter_in;
   logic [POS_W-1:0]   byte_pos_ff, byte_pos_in;
   logic [7:0]         data_ff, data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;

   block_type          init_words;
   block_type          ks_words;
   core_status_type    core_status;
   logic               core_start;
   logic               out_free;
   logic               req_fire;
   logic               csr_fire;
   logic               cfg_hit;
   logic               need_block;
   logic [WORD_W-1:0]  ks_word;
   logic [7:0]         ks_byte;

   // Initial block state: constants, key, counter, nonce.
   always_comb begin
      init_words[0] = SIGMA0;
      init_words[1] = SIGMA1;
      init_words[2] = SIGMA2;
      init_words[3] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
         init_words[4 + 2*i] = key_ff[i][31:0];
         init_words[5 + 2*i] = key_ff[i][63:32];
      end
      init_words[12] = counter_ff;
      init_words[13] = nonce0_ff[31:0];
      init_words[14] = nonce0_ff[63:32];
      init_words[15] = nonce1_ff;
   end

   chacha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (core_start),
      .init_words (init_words),
      .ks_words   (ks_words),
      .status     (core_status)
   );

   // The result register can take a new byte when empty or draining now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign cfg_hit   = csr_fire && (csr_index < CSR_IDX_W'(NUM_REGS));

   // A byte flagged first always restarts from the current counter.
   assign need_block = req_first_byte || (byte_pos_ff >= POS_W'(BLOCK_BYTES));

   // Keystream words are serialized little-endian.
   assign ks_word = ks_words[byte_pos_ff[5:2]];
   assign ks_byte = ks_word[{byte_pos_ff[1:0], 3'b000} +: 8];

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      nonce0_in    = nonce0_ff;
      nonce1_in    = nonce1_ff;
      init_ctr_in  = init_ctr_ff;
      counter_in   = counter_ff;
      byte_pos_in  = byte_pos_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      core_start   = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (need_block) begin
                  data_in    = req_data_byte;
                  core_start = 1'b1;
                  state_in   = ST_GEN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_data_byte ^ ks_byte;
                  byte_pos_in  = byte_pos_ff + 1'b1;
               end
            end
         end
         ST_GEN: begin
            if (core_status.done) begin
               byte_pos_in = '0;
               counter_in  = counter_ff + 32'd1;
               state_in    = ST_XOR;
            end
         end
         ST_XOR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ ks_byte;
               byte_pos_in  = byte_pos_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Any write to a listed register reloads the counter and drops the
      // current block. Writes beyond the list change nothing.
      if (cfg_hit) begin
         counter_in  = init_ctr_ff;
         byte_pos_in = POS_W'(BLOCK_BYTES);
         unique case (csr_index) inside
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
               key_in[csr_index[1:0]] = csr_data;
            end
            REG_NONCE0: begin
               nonce0_in = csr_data;
            end
            REG_NONCE1: begin
               nonce1_in = csr_data[31:0];
            end
            REG_CTR: begin
               init_ctr_in = csr_data[31:0];
               counter_in  = csr_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         nonce0_ff    <= '0;
         nonce1_ff    <= '0;
         init_ctr_ff  <= '0;
         counter_ff   <= '0;
         byte_pos_ff  <= POS_W'(BLOCK_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         nonce0_ff    <= nonce0_in;
         nonce1_ff    <= nonce1_in;
         init_ctr_ff  <= init_ctr_in;
         counter_ff   <= counter_in;
         byte_pos_ff  <= byte_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // A byte flagged first must always wait for a fresh block.
   `CSX_ASSERT_NEXT(a_first_regen, req_valid && req_ready && req_first_byte, state_ff == ST_GEN, "first byte did not start a new block")
   // A finished block restarts the byte position at zero.
   `CSX_ASSERT_NEXT(a_done_restart, state_ff == ST_GEN && core_status.done, byte_pos_ff == '0 && state_ff == ST_XOR, "new block did not restart at byte zero")
   // Each finished block advances the counter by exactly one.
   `CSX_ASSERT_NEXT(a_ctr_step, state_ff == ST_GEN && core_status.done, counter_ff == $past(counter_ff) + 32'd1, "block counter did not advance by one")
   // The byte position never runs past the end of a block.
   `CSX_ASSERT_NOW(a_pos_bound, 1'b1, byte_pos_ff <= POS_W'(BLOCK_BYTES), "byte position beyond block end")

endmodule
